// ===== design/dhr_pkg.sv =====
// ----------------------------------------------------------------------------
// dhr_pkg
// Shared constants, command codes and helpers for the halo raster unit
// ----------------------------------------------------------------------------
package dhr_pkg;

    localparam int FbWidthDef   = 320;
    localparam int FbHeightDef  = 240;
    localparam int MaxRadiusDef = 255;

    localparam logic [1:0] CMD_HALO  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam logic [15:0] RB_FIELDS   = 16'hf81f;
    localparam logic [15:0] G_FIELD     = 16'h07c0;
    localparam logic [5:0]  FULL_WEIGHT = 6'd32;

    typedef struct packed {
        logic [1:0]  command;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [7:0]  radius;
        logic [15:0] color;
        logic [7:0]  alpha;
    } t_cmd;

    function automatic logic [3:0] bayer4(input logic [3:0] idx);
        logic [3:0] v;
        case (idx)
            4'd0:  v = 4'd0;
            4'd1:  v = 4'd8;
            4'd2:  v = 4'd2;
            4'd3:  v = 4'd10;
            4'd4:  v = 4'd12;
            4'd5:  v = 4'd4;
            4'd6:  v = 4'd14;
            4'd7:  v = 4'd6;
            4'd8:  v = 4'd3;
            4'd9:  v = 4'd11;
            4'd10: v = 4'd1;
            4'd11: v = 4'd9;
            4'd12: v = 4'd15;
            4'd13: v = 4'd7;
            4'd14: v = 4'd13;
            default: v = 4'd5;
        endcase
        return v;
    endfunction

endpackage

// ===== design/dhr_stream_if.sv =====
// ----------------------------------------------------------------------------
// dhr_stream_if
// Valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
interface dhr_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/dhr_divider.sv =====
// ----------------------------------------------------------------------------
// dhr_divider
// Restoring divider, one quotient bit per cycle (27-bit dividend, 16-bit divisor)
// ----------------------------------------------------------------------------
module dhr_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [26:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_done,
    output logic [26:0] o_quot
);
    logic [26:0] r_quot, n_quot;
    logic [15:0] r_rem, n_rem;
    logic [15:0] r_den, n_den;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [16:0] trial;

    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        trial  = {r_rem, r_quot[26]};
        if (i_start) begin
            n_quot = i_num;
            n_rem  = '0;
            n_den  = i_den;
            n_cnt  = 5'd27;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                n_rem  = 16'(trial - {1'b0, r_den});
                n_quot = {r_quot[25:0], 1'b1};
            end else begin
                n_rem  = trial[15:0];
                n_quot = {r_quot[25:0], 1'b0};
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_den  <= n_den;
    end

    assign o_done = r_busy && (r_cnt == 5'd1);
    assign o_quot = n_quot;
endmodule

// ===== design/dithered_halo_raster_unit.sv =====
// ----------------------------------------------------------------------------
// dithered_halo_raster_unit
// Frame store with pixel write, pixel read and dithered halo drawing
// ----------------------------------------------------------------------------
// A write holds the block while it passes through S_WR. A read offers its
// beat once S_RD and S_OUT have run and holds the block until the beat is
// taken. A halo walks its rows and covered pixels one at a time through a
// single shared divider: a row outside the store or the disc is stepped over
// in S_ROW; a covered row runs the row test, an 8-step square-root search for
// the half-width, clipping and the end-of-row test; each covered pixel runs
// the bit-serial divider (27 steps) and the read-modify-write of the frame
// store, skipping the write where its alpha comes out zero. The block is not
// ready while a command runs. No clearing pass after reset.
module dithered_halo_raster_unit #(
    parameter int FB_WIDTH   = dhr_pkg::FbWidthDef,
    parameter int FB_HEIGHT  = dhr_pkg::FbHeightDef,
    parameter int MAX_RADIUS = dhr_pkg::MaxRadiusDef
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dhr_stream_if.sink   i_cmd,
    dhr_stream_if.source o_pix
);
    localparam int Depth = FB_WIDTH * FB_HEIGHT;
    localparam int AW    = $clog2(Depth);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WR    = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_OUT   = 4'd3;
    localparam logic [3:0] S_WAIT  = 4'd4;
    localparam logic [3:0] S_ROW   = 4'd5;
    localparam logic [3:0] S_SQRT  = 4'd6;
    localparam logic [3:0] S_PIX   = 4'd7;
    localparam logic [3:0] S_MUL   = 4'd8;
    localparam logic [3:0] S_NUM   = 4'd9;
    localparam logic [3:0] S_DIV   = 4'd10;
    localparam logic [3:0] S_RMW   = 4'd11;
    localparam logic [3:0] S_BLEND = 4'd12;

    logic [15:0] mem [Depth];

    logic [3:0]  r_st;
    logic signed [12:0] r_ox, r_oy;
    logic [7:0]  r_r;
    logic [15:0] r_rr;
    logic [15:0] r_color;
    logic [10:0] r_a8;
    logic signed [9:0] r_y;
    logic [16:0] r_remr;
    logic [7:0]  r_h;
    logic [7:0]  r_bit;
    logic signed [9:0] r_x, r_x1;
    logic [16:0] r_part;
    logic [5:0]  r_al;
    logic [AW-1:0] r_addr;
    logic [15:0] r_rd;
    logic [15:0] r_out;
    logic        r_ovalid;
    logic        r_inb;

    logic        div_start, div_done;
    logic [26:0] div_q;
    logic [26:0] num_c;

    dhr_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (num_c),
        .i_den  (r_rr),
        .o_done (div_done),
        .o_quot (div_q)
    );

    dhr_pkg::t_cmd c;
    logic signed [12:0] cx, cy;
    logic in_range;
    logic [7:0] rs;
    logic signed [12:0] rsx;
    logic signed [12:0] py, col;
    logic [16:0] yy;
    logic signed [17:0] rem_s;
    logic [15:0] hc2;
    logic [7:0] hc;
    logic signed [12:0] xl, xr;
    logic [16:0] xx;
    logic [3:0] dith;
    logic [27:0] qsum;
    logic [24:0] al_c;
    logic [21:0] rb, gr;
    logic [5:0] keep;
    logic [15:0] blended;

    assign c        = i_cmd.data;
    assign cx       = {c.pos_x[11], c.pos_x};
    assign cy       = {c.pos_y[11], c.pos_y};
    assign in_range = !cx[12] && (cx < 13'(FB_WIDTH)) && !cy[12] && (cy < 13'(FB_HEIGHT));
    assign rs       = (c.radius > 8'(MAX_RADIUS)) ? 8'(MAX_RADIUS) : c.radius;
    assign rsx      = $signed({5'b0, rs});
    assign py       = r_oy + 13'(r_y);
    assign col      = r_ox + 13'(r_x);
    assign yy       = 17'(r_y * r_y);
    assign rem_s    = $signed({2'b0, r_rr}) - $signed({1'b0, yy});
    assign hc       = r_h | r_bit;
    assign hc2      = 16'(hc) * 16'(hc);
    assign xl       = -$signed({5'b0, r_h});
    assign xr       = $signed({5'b0, r_h});
    assign xx       = 17'(r_x * r_x);
    assign num_c    = 27'(r_a8) * 27'(r_part);
    assign dith     = dhr_pkg::bayer4({py[1:0], col[1:0]});
    assign qsum     = {1'b0, div_q} + 28'(dith >> 1);
    assign al_c     = qsum[27:3];
    assign keep     = dhr_pkg::FULL_WEIGHT - r_al;
    assign rb       = 22'(r_rd & dhr_pkg::RB_FIELDS) * keep
                    + 22'(r_color & dhr_pkg::RB_FIELDS) * r_al;
    assign gr       = 22'(r_rd & dhr_pkg::G_FIELD) * keep
                    + 22'(r_color & dhr_pkg::G_FIELD) * r_al;
    assign blended  = (rb[20:5] & dhr_pkg::RB_FIELDS) | (gr[20:5] & dhr_pkg::G_FIELD);

    assign i_cmd.ready = (r_st == S_IDLE);
    assign o_pix.valid = r_ovalid;
    assign o_pix.data  = r_out;
    assign div_start   = (r_st == S_NUM);

    always_ff @(posedge i_clk) begin
        if (r_st == S_RD || r_st == S_RMW) begin
            r_rd <= mem[r_addr];
        end
        if (r_st == S_WR && r_inb) begin
            mem[r_addr] <= r_color;
        end else if (r_st == S_BLEND) begin
            mem[r_addr] <= (r_al >= dhr_pkg::FULL_WEIGHT) ? r_color : blended;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_ox    <= cx;
                        r_oy    <= cy;
                        r_color <= c.color;
                        r_r     <= rs;
                        r_rr    <= 16'(rs) * 16'(rs);
                        r_a8    <= {c.alpha, 3'b0};
                        r_y     <= -$signed({2'b0, rs});
                        r_inb   <= in_range;
                        r_addr  <= in_range ? AW'(32'(cy[11:0]) * FB_WIDTH + 32'(cx[11:0]))
                                            : '0;
                        case (c.command)
                            dhr_pkg::CMD_WRITE: r_st <= S_WR;
                            dhr_pkg::CMD_READ:  r_st <= S_RD;
                            dhr_pkg::CMD_HALO: begin
                                if (rs == 8'd0 || c.alpha == 8'd0
                                    || (cx + rsx < 13'sd0)
                                    || (cx - rsx > 13'(FB_WIDTH - 1))
                                    || (cy + rsx < 13'sd0)
                                    || (cy - rsx > 13'(FB_HEIGHT - 1))) begin
                                    r_st <= S_IDLE;
                                end else begin
                                    r_st <= S_ROW;
                                end
                            end
                            default: r_st <= S_IDLE;
                        endcase
                    end
                end
                S_WR: begin
                    r_st <= S_IDLE;
                end
                S_RD: begin
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    r_out    <= r_inb ? r_rd : 16'd0;
                    r_ovalid <= 1'b1;
                    r_st     <= S_WAIT;
                end
                S_WAIT: begin
                    if (o_pix.ready) begin
                        r_ovalid <= 1'b0;
                        r_st     <= S_IDLE;
                    end
                end
                S_ROW: begin
                    if (r_y > $signed({2'b0, r_r})) begin
                        r_st <= S_IDLE;
                    end else if (py < 0 || py >= 13'(FB_HEIGHT) || rem_s <= 0) begin
                        r_y <= r_y + 10'sd1;
                    end else begin
                        r_remr <= rem_s[16:0];
                        r_h    <= 8'd0;
                        r_bit  <= 8'd128;
                        r_st   <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if ({1'b0, hc2} < r_remr) r_h <= hc;
                    r_bit <= r_bit >> 1;
                    if (r_bit == 8'd1) r_st <= S_PIX;
                end
                S_PIX: begin
                    r_x  <= (r_ox + xl < 0) ? 10'(-r_ox) : 10'(xl);
                    r_x1 <= (r_ox + xr > 13'(FB_WIDTH - 1)) ? 10'(13'(FB_WIDTH - 1) - r_ox)
                                                            : 10'(xr);
                    r_st <= S_MUL;
                end
                S_MUL: begin
                    if (r_x > r_x1) begin
                        r_y  <= r_y + 10'sd1;
                        r_st <= S_ROW;
                    end else begin
                        r_part <= r_remr - xx;
                        r_addr <= AW'(32'(py[11:0]) * FB_WIDTH + 32'(col[11:0]));
                        r_st   <= S_NUM;
                    end
                end
                S_NUM: begin
                    r_st <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_al <= (al_c >= 25'd32) ? dhr_pkg::FULL_WEIGHT : {1'b0, al_c[4:0]};
                        r_st <= S_RMW;
                    end
                end
                S_RMW: begin
                    if (r_al == 6'd0) begin
                        r_x  <= r_x + 10'sd1;
                        r_st <= S_MUL;
                    end else begin
                        r_st <= S_BLEND;
                    end
                end
                S_BLEND: begin
                    r_x  <= r_x + 10'sd1;
                    r_st <= S_MUL;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== tb/sv/dhr_halo_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhr_halo_checker
// Watches the command and pixel channels of the halo raster unit, keeps its
// own copy of the frame store, predicts every read and compares each result
// ----------------------------------------------------------------------------
module dhr_halo_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  logic           i_cmd_ready,
    input  dhr_pkg::t_cmd  i_cmd_data,
    input  logic           i_pix_valid,
    input  logic           i_pix_ready,
    input  logic [15:0]    i_pix_data,
    output int             o_errors,
    output int             o_pending
);
    localparam int W = dhr_pkg::FbWidthDef;
    localparam int H = dhr_pkg::FbHeightDef;

    logic [15:0] store_model [0:W*H-1];
    logic [15:0] pixel_q [$];
    int          dither_lut [16] = '{0, 8, 2, 10, 12, 4, 14, 6, 3, 11, 1, 9, 15, 7, 13, 5};
    int          err_cnt = 0;
    int          pend_cnt = 0;

    assign o_errors  = err_cnt;
    assign o_pending = pend_cnt;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    function automatic logic [15:0] mix565(logic [15:0] dst, logic [15:0] src, int w);
        logic [31:0] rb;
        logic [31:0] gr;
        rb = ((32'(dst & dhr_pkg::RB_FIELDS)) * (32 - w)
              + (32'(src & dhr_pkg::RB_FIELDS)) * w) >> 5;
        gr = ((32'(dst & dhr_pkg::G_FIELD)) * (32 - w)
              + (32'(src & dhr_pkg::G_FIELD)) * w) >> 5;
        return (rb[15:0] & dhr_pkg::RB_FIELDS) | (gr[15:0] & dhr_pkg::G_FIELD);
    endfunction

    function automatic void paint_halo(int ox, int oy, int rad, logic [15:0] colr, int a);
        int rr, y, py, rem, hw, x0, x1, x, c, q, d, al, idx;
        if (rad > dhr_pkg::MaxRadiusDef) rad = dhr_pkg::MaxRadiusDef;
        if (rad < 1 || a == 0) return;
        if (ox + rad < 0 || ox - rad > W - 1 || oy + rad < 0 || oy - rad > H - 1) return;
        rr = rad * rad;
        for (y = -rad; y <= rad; y++) begin
            py  = oy + y;
            rem = rr - y * y;
            if (py < 0 || py >= H || rem <= 0) continue;
            hw = 0;
            while ((hw + 1) * (hw + 1) < rem) hw++;
            x0 = -hw;
            x1 = hw;
            if (ox + x0 < 0) x0 = -ox;
            if (ox + x1 > W - 1) x1 = W - 1 - ox;
            for (x = x0; x <= x1; x++) begin
                c   = ox + x;
                q   = (a * 8 * (rem - x * x)) / rr;
                d   = dither_lut[((py & 3) << 2) | (c & 3)] >> 1;
                al  = (q + d) >> 3;
                idx = py * W + c;
                if (al == 0) continue;
                store_model[idx] = (al >= 32) ? colr : mix565(store_model[idx], colr, al);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        int px, py;
        logic [15:0] want;
        if (!i_rst_n) begin
            pixel_q.delete();
            for (int i = 0; i < W*H; i++) store_model[i] = 16'h0000;
            pend_cnt = 0;
        end else begin
            if (i_pix_valid && i_pix_ready) begin
                if (pixel_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected pixel beat %h", i_pix_data));
                end else begin
                    want = pixel_q.pop_front();
                    if (i_pix_data !== want)
                        report_mismatch($sformatf("pixel_value %h, want %h", i_pix_data, want));
                end
            end
            if (i_cmd_valid && i_cmd_ready) begin
                px = $signed(i_cmd_data.pos_x);
                py = $signed(i_cmd_data.pos_y);
                case (i_cmd_data.command)
                    dhr_pkg::CMD_HALO: paint_halo(px, py, int'(i_cmd_data.radius),
                                                  i_cmd_data.color, int'(i_cmd_data.alpha));
                    dhr_pkg::CMD_WRITE: begin
                        if (px >= 0 && px < W && py >= 0 && py < H)
                            store_model[py * W + px] = i_cmd_data.color;
                    end
                    dhr_pkg::CMD_READ: begin
                        if (px >= 0 && px < W && py >= 0 && py < H)
                            pixel_q.push_back(store_model[py * W + px]);
                        else
                            pixel_q.push_back(16'h0000);
                    end
                    default: ;
                endcase
            end
            pend_cnt = pixel_q.size();
        end
    end
endmodule

// ===== tb/sv/tb_dithered_halo_raster_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dithered_halo_raster_unit
// Stimulus for the halo raster unit: directed corner cases, then random
// writes, reads and small halos around the store corners, with bursty input
// and a stalling receiver; the checker predicts and compares every read
// ----------------------------------------------------------------------------
module tb_dithered_halo_raster_unit;
    localparam int W = dhr_pkg::FbWidthDef;
    localparam int H = dhr_pkg::FbHeightDef;
    localparam int N_RANDOM = 437;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    bit   hold_req;
    bit   written_map [0:W*H-1];
    int   written_list [$];

    dhr_stream_if #(.t_payload(dhr_pkg::t_cmd)) cmd_if ();
    dhr_stream_if #(.t_payload(logic [15:0]))   pix_if ();

    dithered_halo_raster_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_pix   (pix_if)
    );

    dhr_halo_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_if.valid),
        .i_cmd_ready (cmd_if.ready),
        .i_cmd_data  (cmd_if.data),
        .i_pix_valid (pix_if.valid),
        .i_pix_ready (pix_if.ready),
        .i_pix_data  (pix_if.data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("TB_ERROR");
        $finish;
    end

    // receiver ready pattern, with one long hold-off on request
    initial begin
        int mode, span_left, hold_left;
        bit hold_done;
        mode = 0;
        span_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        pix_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                pix_if.ready <= 1'b0;
            end else if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 400;
                pix_if.ready <= 1'b0;
            end else begin
                if (span_left == 0) begin
                    mode = $urandom_range(0, 2);
                    span_left = $urandom_range(20, 200);
                end
                span_left--;
                case (mode)
                    0: pix_if.ready <= 1'b1;
                    1: pix_if.ready <= $urandom_range(0, 1);
                    default: pix_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic dhr_pkg::t_cmd make_cmd(logic [1:0] c, int x, int y, int r, int colr,
                                               int a);
        dhr_pkg::t_cmd t;
        t.command = c;
        t.pos_x   = x[11:0];
        t.pos_y   = y[11:0];
        t.radius  = r[7:0];
        t.color   = colr[15:0];
        t.alpha   = a[7:0];
        return t;
    endfunction

    task automatic send_cmd(input dhr_pkg::t_cmd t);
        int x, y;
        x = $signed(t.pos_x);
        y = $signed(t.pos_y);
        if (t.command == dhr_pkg::CMD_WRITE && x >= 0 && x < W && y >= 0 && y < H
            && !written_map[y * W + x]) begin
            written_map[y * W + x] = 1'b1;
            written_list.push_back(y * W + x);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= t;
        do @(posedge i_clk); while (!cmd_if.ready);
        @(negedge i_clk);
    endtask

    task automatic go_idle(input int n);
        cmd_if.valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    function automatic int corner_x();
        return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : $urandom_range(W - 16, W - 1);
    endfunction

    function automatic int corner_y();
        return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 11) : $urandom_range(H - 12, H - 1);
    endfunction

    function automatic dhr_pkg::t_cmd random_cmd();
        int sel, idx, r;
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
            r = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
            return make_cmd(dhr_pkg::CMD_HALO, corner_x() + $urandom_range(0, 8) - 4,
                            corner_y() + $urandom_range(0, 8) - 4, r,
                            $urandom_range(0, 65535), $urandom_range(0, 255));
        end else if (sel < 60) begin
            return make_cmd(dhr_pkg::CMD_WRITE, corner_x(), corner_y(), 0,
                            $urandom_range(0, 65535), $urandom_range(0, 255));
        end else if (sel < 92 && written_list.size() > 0) begin
            idx = written_list[$urandom_range(0, written_list.size() - 1)];
            return make_cmd(dhr_pkg::CMD_READ, idx % W, idx / W, $urandom_range(0, 255),
                            $urandom_range(0, 65535), $urandom_range(0, 255));
        end else if (sel < 96) begin
            return make_cmd(($urandom_range(0, 1) == 0) ? dhr_pkg::CMD_WRITE : dhr_pkg::CMD_READ,
                            ($urandom_range(0, 1) == 0) ? -$urandom_range(1, 2048)
                                                        : $urandom_range(W, 2047),
                            $urandom_range(0, 4095) - 2048, $urandom_range(0, 255),
                            $urandom_range(0, 65535), $urandom_range(0, 255));
        end else begin
            return make_cmd(dhr_pkg::CMD_SPARE, $urandom_range(0, 4095), $urandom_range(0, 4095),
                            $urandom_range(0, 255), $urandom_range(0, 65535),
                            $urandom_range(0, 255));
        end
    endfunction

    initial begin
        dhr_pkg::t_cmd dir [$];
        int burst_left, gap, wait_n;
        cmd_if.valid = 1'b0;
        cmd_if.data  = '0;
        hold_req = 1'b0;
        for (int i = 0; i < W*H; i++) written_map[i] = 1'b0;
        i_rst_n = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        dir.push_back(make_cmd(dhr_pkg::CMD_WRITE, 0, 0, 0, 16'h0000, 0));
        dir.push_back(make_cmd(dhr_pkg::CMD_WRITE, W - 1, H - 1, 255, 16'hffff, 255));
        dir.push_back(make_cmd(dhr_pkg::CMD_WRITE, 1, 0, 0, 16'haaaa, 0));
        dir.push_back(make_cmd(dhr_pkg::CMD_WRITE, 3, 2, 0, 16'h5555, 0));
        dir.push_back(make_cmd(dhr_pkg::CMD_WRITE, -1, 5, 0, 16'h1234, 0));
        dir.push_back(make_cmd(dhr_pkg::CMD_WRITE, 2047, -2048, 0, 16'h4321, 0));
        dir.push_back(make_cmd(dhr_pkg::CMD_READ, -2048, 2047, 0, 0, 0));
        dir.push_back(make_cmd(dhr_pkg::CMD_READ, W, 0, 0, 0, 0));
        dir.push_back(make_cmd(dhr_pkg::CMD_READ, 0, H, 0, 0, 0));
        dir.push_back(make_cmd(dhr_pkg::CMD_READ, W - 1, H - 1, 0, 0, 0));
        dir.push_back(make_cmd(dhr_pkg::CMD_HALO, 2, 1, 3, 16'hf800, 255));
        dir.push_back(make_cmd(dhr_pkg::CMD_HALO, 1, 1, 4, 16'h07e0, 0));
        dir.push_back(make_cmd(dhr_pkg::CMD_HALO, 1, 1, 0, 16'h07e0, 200));
        dir.push_back(make_cmd(dhr_pkg::CMD_HALO, 2, 2, 5, 16'h001f, 1));
        dir.push_back(make_cmd(dhr_pkg::CMD_HALO, 3, 1, 6, 16'hffff, 16));
        dir.push_back(make_cmd(dhr_pkg::CMD_HALO, W - 2, H - 2, 3, 16'h0000, 100));
        dir.push_back(make_cmd(dhr_pkg::CMD_HALO, -2048, -2048, 255, 16'hffff, 255));
        dir.push_back(make_cmd(dhr_pkg::CMD_HALO, -240, 120, 255, 16'h7bef, 200));
        dir.push_back(make_cmd(dhr_pkg::CMD_SPARE, 5, 5, 9, 16'hffff, 255));
        dir.push_back(make_cmd(dhr_pkg::CMD_READ, 0, 0, 0, 0, 0));
        dir.push_back(make_cmd(dhr_pkg::CMD_READ, 1, 0, 0, 0, 0));
        dir.push_back(make_cmd(dhr_pkg::CMD_READ, 3, 2, 0, 0, 0));
        dir.push_back(make_cmd(dhr_pkg::CMD_READ, W - 1, H - 1, 0, 0, 0));
        foreach (dir[i]) send_cmd(dir[i]);

        burst_left = 0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 150) hold_req = 1'b1;
            if (n == 300) begin
                cmd_if.valid <= 1'b0;
                do @(negedge i_clk); while (pending != 0);
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) go_idle(gap);
            end
            burst_left--;
            send_cmd(random_cmd());
        end
        cmd_if.valid <= 1'b0;

        wait_n = 0;
        while ((pending != 0 || !cmd_if.ready) && wait_n < 500000) begin
            @(negedge i_clk);
            wait_n++;
        end
        repeat (40) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
